@@ design/tonq_pkg.sv @@
// Shared types and constants for the timestamp-ordered node queue.
// No dependencies; imported by every module of the block.
package tonq_pkg;

   localparam int POOL_NODES = 64;
   localparam int NODE_W     = $clog2(POOL_NODES);
   localparam int CNT_W      = $clog2(POOL_NODES + 1);
   localparam int HANDLE_W   = 6;
   localparam int SEC_W      = 32;
   localparam int USEC_W     = 20;
   localparam int COUNT_W    = 7;
   localparam int TIME_W     = SEC_W + USEC_W;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_BAD_HANDLE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEQ_INIT,
      SEQ_WARM,
      SEQ_IDLE,
      SEQ_SETTLE
   } seq_type;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] handle;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic              ins;
      logic              rem;
      entry_type         new_entry;
      logic [NODE_W-1:0] rem_handle;
   } cell_op_type;

endpackage

@@ design/tonq_cell.sv @@
// One slot of the sorted used queue; slots shift left or right as a row.
// Depends on tonq_pkg.
module tonq_cell import tonq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cell_op_type op,
   input  entry_type   left_entry,
   input  entry_type   right_entry,
   input  logic        left_less,
   input  logic        left_gone,
   output entry_type   entry,
   output logic        less,
   output logic        gone
);

   entry_type entry_ff, entry_in;
   logic      match;

   assign less  = entry_ff.valid && (entry_ff.stamp < op.new_entry.stamp);
   assign match = entry_ff.valid && (entry_ff.handle == op.rem_handle);
   assign gone  = left_gone | match;
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (op.ins) begin
         // strictly earlier words stay put; the new word lands ahead of equals
         if (!less) begin
            entry_in = left_less ? op.new_entry : left_entry;
         end
      end else if (op.rem) begin
         if (gone) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

@@ design/tonq_free_fifo.sv @@
// Ring of free node handles, served first in, first out, with registered head.
// Filled in index order by a sweep after reset. Depends on tonq_pkg.
module tonq_free_fifo import tonq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop,
   input  logic              push,
   input  logic [NODE_W-1:0] push_handle,
   output logic [NODE_W-1:0] head_handle,
   output logic [CNT_W-1:0]  count,
   output logic              filled
);

   logic [NODE_W-1:0] mem [POOL_NODES];
   logic [NODE_W-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [NODE_W-1:0] fill_ptr_ff;
   logic              filled_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [NODE_W-1:0] head_ff;

   function automatic logic [NODE_W-1:0] wrap_inc(input logic [NODE_W-1:0] p);
      return (p == NODE_W'(POOL_NODES - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      rd_ptr_in = pop  ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in = push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      count_in  = count_ff;
      if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         count_ff    <= CNT_W'(POOL_NODES);
         fill_ptr_ff <= '0;
         filled_ff   <= 1'b0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         if (!filled_ff) begin
            fill_ptr_ff <= wrap_inc(fill_ptr_ff);
            if (fill_ptr_ff == NODE_W'(POOL_NODES - 1)) begin
               filled_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!filled_ff) begin
         mem[fill_ptr_ff] <= fill_ptr_ff;
      end else if (push) begin
         mem[wr_ptr_ff] <= push_handle;
      end
      head_ff <= mem[rd_ptr_ff];
   end

   assign head_handle = head_ff;
   assign count       = count_ff;
   assign filled      = filled_ff;

endmodule

@@ design/timestamp_ordered_node_queue_core.sv @@
// Timestamp-ordered node queue: top level with control, in-use flags and
// the row of sorted cells. Depends on tonq_pkg, tonq_cell, tonq_free_fifo.
//
// Input channel req_*: mode 0 allocates the oldest free node and inserts it
// into the used queue in timestamp order (ahead of equal times); mode 1
// recycles req_node_handle back to the tail of the free list.
// Result channel rsp_*: one word per request with status, the handle
// given, the head of the used queue and the used count after the step.
// Each request runs in order: the accept edge updates the cell row and
// free ring, the SETTLE state registers the result while the ring's registered
// read settles, and the result word then holds until it leaves.
// A new request is taken only once the previous result has left.
// After reset the free ring is filled in index order, one handle a cycle;
// req_stall stays high through the fill and the SEQ_INIT and SEQ_WARM states.
// While rsp_stall is high the result word holds and req_stall stays high.
module timestamp_ordered_node_queue_core import tonq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [SEC_W-1:0]    req_time_seconds,
   input  logic [USEC_W-1:0]   req_time_microseconds,
   input  logic [HANDLE_W-1:0] req_node_handle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [HANDLE_W-1:0] rsp_given_handle,
   output logic                rsp_head_valid,
   output logic [HANDLE_W-1:0] rsp_head_handle,
   output logic [SEC_W-1:0]    rsp_head_seconds,
   output logic [USEC_W-1:0]   rsp_head_microseconds,
   output logic [COUNT_W-1:0]  rsp_used_count
);

   seq_type           seq_ff, seq_in;
   logic              accept;
   logic              handle_ok;
   logic [NODE_W-1:0] req_idx;
   logic              do_alloc, do_recycle;
   logic [POOL_NODES-1:0] in_use_ff;
   logic [CNT_W-1:0]  used_ff;
   status_type        status_ff, status_in;
   logic [NODE_W-1:0] given_ff, given_in;
   logic              rsp_valid_ff;
   logic [NODE_W-1:0] free_head;
   logic [CNT_W-1:0]  free_count;
   logic              filled;
   cell_op_type       op;

   entry_type         cell_entry [POOL_NODES];
   logic [POOL_NODES-1:0] cell_less, cell_gone;

   assign req_stall = (seq_ff != SEQ_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign req_idx   = NODE_W'(req_node_handle);
   assign handle_ok = (32'(req_node_handle) < POOL_NODES) && in_use_ff[req_idx];

   always_comb begin
      do_alloc   = 1'b0;
      do_recycle = 1'b0;
      status_in  = ST_OK;
      given_in   = '0;
      if (!req_mode) begin
         if (free_count == '0) begin
            status_in = ST_FULL;
         end else begin
            do_alloc = accept;
            given_in = free_head;
         end
      end else begin
         given_in = req_idx;
         if (handle_ok) begin
            do_recycle = accept;
         end else begin
            status_in = ST_BAD_HANDLE;
         end
      end
      op.ins                = do_alloc;
      op.rem                = do_recycle;
      op.new_entry.valid    = 1'b1;
      op.new_entry.handle   = free_head;
      op.new_entry.stamp    = {req_time_seconds, req_time_microseconds};
      op.rem_handle         = req_idx;
   end

   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_INIT:   if (filled) seq_in = SEQ_WARM;
         SEQ_WARM:   seq_in = SEQ_IDLE;
         SEQ_IDLE:   if (accept) seq_in = SEQ_SETTLE;
         SEQ_SETTLE: seq_in = SEQ_IDLE;
         default:    seq_in = SEQ_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_INIT;
         in_use_ff    <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         if (do_alloc) begin
            in_use_ff[free_head] <= 1'b1;
            used_ff              <= used_ff + 1'b1;
         end else if (do_recycle) begin
            in_use_ff[req_idx] <= 1'b0;
            used_ff            <= used_ff - 1'b1;
         end
         if (seq_ff == SEQ_SETTLE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         given_ff  <= given_in;
      end
      if (seq_ff == SEQ_SETTLE) begin
         rsp_status       <= status_ff;
         rsp_given_handle <= HANDLE_W'(given_ff);
         rsp_head_valid   <= cell_entry[0].valid;
         rsp_head_handle  <= cell_entry[0].valid ? HANDLE_W'(cell_entry[0].handle) : '0;
         rsp_head_seconds <= cell_entry[0].valid ?
                             cell_entry[0].stamp[TIME_W-1:USEC_W] : '0;
         rsp_head_microseconds <= cell_entry[0].valid ?
                                  cell_entry[0].stamp[USEC_W-1:0] : '0;
         rsp_used_count   <= COUNT_W'(used_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   tonq_free_fifo u_free (
      .clock       (clock),
      .reset       (reset),
      .pop         (do_alloc),
      .push        (do_recycle),
      .push_handle (req_idx),
      .head_handle (free_head),
      .count       (free_count),
      .filled      (filled)
   );

   for (genvar i = 0; i < POOL_NODES; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      l_less, l_gone;
      if (i == 0) begin : g_first
         assign left_e = '0;
         assign l_less = 1'b1;
         assign l_gone = 1'b0;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign l_less = cell_less[i-1];
         assign l_gone = cell_gone[i-1];
      end
      if (i == POOL_NODES - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end
      tonq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_less   (l_less),
         .left_gone   (l_gone),
         .entry       (cell_entry[i]),
         .less        (cell_less[i]),
         .gone        (cell_gone[i])
      );
   end

endmodule
